// File: hdl/pcsb_pkg.sv
// shared types, constants and codes of the coincidence sinogram binner
`default_nettype none

package pcsb_pkg;

    localparam int RADIAL_BINS_DEF = 64;
    localparam int ANGLE_BINS_DEF  = 128;
    localparam int MAX_RINGS_DEF   = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_TAN_CRYSTALS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_SUBMODULES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_MODULES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIAL_CRYSTALS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIAL_SUBMODULES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RSECTOR_COUNT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RING_DIFF    = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RING_OOR  = 3'd1;
    localparam logic [2:0] ST_RING_DIFF = 3'd2;
    localparam logic [2:0] ST_BIN_OOR   = 3'd3;
    localparam logic [2:0] ST_SAT       = 3'd4;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // divider operand width, covers crystal index sum plus half ring
    localparam int DIV_W  = 24;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int RING_W = 19;
    localparam int XTAL_W = 22;
    localparam int SUM_W  = 23;
    localparam int TOT_W  = 22;
    localparam int SGN_W  = 25;
    localparam int BIN_W  = 10;
    localparam int ID_STEPS = 8;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic       op;
        logic [5:0] rsector_a;
        logic [7:0] module_a;
        logic [7:0] submodule_a;
        logic [7:0] crystal_a;
        logic [5:0] rsector_b;
        logic [7:0] module_b;
        logic [7:0] submodule_b;
        logic [7:0] crystal_b;
        logic [5:0] read_radial;
        logic [6:0] read_angle;
        logic [5:0] read_plane;
    } evt_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  radial_bin;
        logic [6:0]  angle_bin;
        logic [5:0]  plane;
        logic [15:0] count;
    } res_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

`default_nettype wire

// File: hdl/pcsb_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module pcsb_div
    import pcsb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         req,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic      [DIV_W-1:0] quo,
    output logic      [DIV_W-1:0] rem,
    output logic                  done
);

    localparam int IDX_W = $clog2(DIV_W);

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W:0]    trial;
    logic [STEP_W-1:0] cnt_dec;
    logic              ge;

    always_comb
    begin
        cnt_dec = cnt_reg - 1'b1;
        trial   = {rem_reg, dvd_reg[IDX_W'(cnt_dec)]};
        ge      = trial >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            cnt_next = req.steps;
            dvd_next = dividend;
            dvs_next = divisor;
            quo_next = '0;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_dec;
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            done_next = (cnt_dec == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: hdl/pcsb_hist.sv
// histogram bin memory with clearing sweep after reset
`default_nettype none

module pcsb_hist #(
    parameter int DEPTH = 524288,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata,
    output logic               busy
);

    logic [15:0]   mem [DEPTH];
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_busy_reg, clr_busy_next;
    logic [15:0]   rdata_reg;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

`default_nettype wire

// File: hdl/pet_coincidence_sinogram_binner.sv
// top level of the coincidence sinogram binner: sequencer, geometry datapath, histogram
//
// An add transaction runs six 8-step divisions of the module, submodule and crystal IDs
// and one 24-step modulo for the angle bin on a single shared divider. After the ID
// divisions come the ring, check and sum states, then the modulo, then the bin, address,
// read, write and output states; the next event is taken in the cycle after the result
// becomes valid. An event dropped for its rings skips the modulo and the histogram
// access, one dropped for its bin skips the histogram access, and a read skips the
// divisions. A result that is still stalled holds the block in its output state. After
// reset the histogram is cleared one bin per cycle, RADIAL_BINS*ANGLE_BINS*MAX_RINGS^2
// bins (524288 at the defaults), and events stall meanwhile; write configuration only
// while no transaction is in flight.
`default_nettype none

module pet_coincidence_sinogram_binner
    import pcsb_pkg::*;
#(
    parameter int RADIAL_BINS = RADIAL_BINS_DEF,
    parameter int ANGLE_BINS  = ANGLE_BINS_DEF,
    parameter int MAX_RINGS   = MAX_RINGS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  evt_valid,
    output logic                       evt_stall,
    input  wire evt_t                  evt,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output res_t                       res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PLANES    = MAX_RINGS * MAX_RINGS;
    localparam int BIN_TOTAL = RADIAL_BINS * ANGLE_BINS * PLANES;
    localparam int AW        = (BIN_TOTAL > 1) ? $clog2(BIN_TOTAL) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DSTART = 4'd1;
    localparam logic [3:0] S_DWAIT  = 4'd2;
    localparam logic [3:0] S_RING   = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_SUM    = 4'd5;
    localparam logic [3:0] S_RAD    = 4'd6;
    localparam logic [3:0] S_ADDR   = 4'd7;
    localparam logic [3:0] S_RD     = 4'd8;
    localparam logic [3:0] S_WR     = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_RCHK   = 4'd11;

    localparam logic [2:0] DSEL_LAST_ID = 3'd5;
    localparam logic [2:0] DSEL_MOD     = 3'd6;

    // configuration
    logic [4:0] tc_reg, ts_reg, tm_reg, ac_reg, as_reg;
    logic [6:0] rc_reg;
    logic [3:0] ring_count_reg;
    logic [2:0] mrd_reg;
    logic [4:0] tc_nz, ts_nz, tm_nz;
    logic [6:0] rc_nz;

    // derived geometry products
    logic [9:0]       tstc_reg;
    logic [14:0]      tmtstc_reg;
    logic [TOT_W-1:0] tot_reg;
    logic [9:0]       asac_reg;
    logic [TOT_W:0]   th_reg;
    logic [TOT_W-1:0] half;

    // sequencer and datapath
    logic [3:0]        state_reg, state_next;
    logic [2:0]        dsel_reg, dsel_next;
    evt_t              evt_reg;
    logic [7:0]        q_reg [6];
    logic [7:0]        r_reg [6];
    logic [RING_W-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [XTAL_W-1:0] c1_reg, c1_next, c2_reg, c2_next, ad_reg, ad_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [7:0]        plane_reg, plane_next;
    logic [BIN_W-1:0]  radial_reg, radial_next, angle_reg, angle_next;
    logic [AW-1:0]     addr_reg, addr_next;
    res_t              pend_reg, pend_next;
    res_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    div_req_t         div_req;
    logic [DIV_W-1:0] div_dvd, div_dvs, div_quo, div_rem;
    logic             div_done;

    logic        mem_we;
    logic [15:0] mem_wdata, mem_rdata;
    logic        clr_busy;

    logic [RING_W-1:0] rdiff;
    logic [SUM_W:0]    sum_half;
    logic [DIV_W-1:0]  angle_full;
    logic              fold;
    logic signed [SGN_W-1:0] diff, hdiff, radial;
    logic              bin_bad;

    assign tc_nz = (tc_reg == '0) ? 5'd1 : tc_reg;
    assign ts_nz = (ts_reg == '0) ? 5'd1 : ts_reg;
    assign tm_nz = (tm_reg == '0) ? 5'd1 : tm_reg;
    assign rc_nz = (rc_reg == '0) ? 7'd1 : rc_reg;
    assign half  = tot_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg         <= 5'd8;
            ts_reg         <= 5'd1;
            tm_reg         <= 5'd1;
            ac_reg         <= 5'd8;
            as_reg         <= 5'd1;
            rc_reg         <= 7'd32;
            ring_count_reg <= 4'd8;
            mrd_reg        <= 3'd7;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TAN_CRYSTALS:     tc_reg         <= cfg_data[4:0];
                CFG_TAN_SUBMODULES:   ts_reg         <= cfg_data[4:0];
                CFG_TAN_MODULES:      tm_reg         <= cfg_data[4:0];
                CFG_AXIAL_CRYSTALS:   ac_reg         <= cfg_data[4:0];
                CFG_AXIAL_SUBMODULES: as_reg         <= cfg_data[4:0];
                CFG_RSECTOR_COUNT:    rc_reg         <= cfg_data;
                CFG_RING_COUNT:       ring_count_reg <= cfg_data[3:0];
                CFG_MAX_RING_DIFF:    mrd_reg        <= cfg_data[2:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        tstc_reg   <= 10'(ts_nz * tc_nz);
        tmtstc_reg <= 15'(tm_nz * tstc_reg);
        tot_reg    <= TOT_W'(rc_nz * tmtstc_reg);
        th_reg     <= (TOT_W + 1)'(({2'b0, tot_reg} + {1'b0, tot_reg, 1'b0}) >> 1);
        asac_reg   <= 10'(as_reg * ac_reg);
    end

    pcsb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quo      (div_quo),
        .rem      (div_rem),
        .done     (div_done)
    );

    pcsb_hist #(
        .DEPTH (BIN_TOTAL),
        .AW    (AW)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata),
        .busy  (clr_busy)
    );

    assign sum_half = {1'b0, sum_reg} + (SUM_W + 1)'(half);

    // divider operand selection
    always_comb
    begin
        div_req.start = (state_reg == S_DSTART);
        div_req.steps = STEP_W'(ID_STEPS);
        div_dvd = '0;
        div_dvs = DIV_W'(1);
        unique case (dsel_reg)
            3'd0:
            begin
                div_dvd = DIV_W'(evt_reg.crystal_a);
                div_dvs = DIV_W'(tc_nz);
            end
            3'd1:
            begin
                div_dvd = DIV_W'(evt_reg.submodule_a);
                div_dvs = DIV_W'(ts_nz);
            end
            3'd2:
            begin
                div_dvd = DIV_W'(evt_reg.module_a);
                div_dvs = DIV_W'(tm_nz);
            end
            3'd3:
            begin
                div_dvd = DIV_W'(evt_reg.crystal_b);
                div_dvs = DIV_W'(tc_nz);
            end
            3'd4:
            begin
                div_dvd = DIV_W'(evt_reg.submodule_b);
                div_dvs = DIV_W'(ts_nz);
            end
            3'd5:
            begin
                div_dvd = DIV_W'(evt_reg.module_b);
                div_dvs = DIV_W'(tm_nz);
            end
            default:
            begin
                div_req.steps = STEP_W'(DIV_W);
                div_dvd = DIV_W'(sum_half);
                div_dvs = DIV_W'(tot_reg);
            end
        endcase
    end

    // radial bin from the crystal difference, angle bin from the modulo result
    always_comb
    begin
        angle_full = div_rem >> 1;
        fold = (SUM_W + 1)'(sum_reg) < (SUM_W + 1)'(th_reg) && sum_reg >= SUM_W'(half);
        if (fold)
        begin
            diff = $signed(SGN_W'(ad_reg)) - $signed(SGN_W'(half));
        end
        else
        begin
            diff = $signed(SGN_W'(half)) - $signed(SGN_W'(ad_reg));
        end
        hdiff  = (diff + $signed(SGN_W'(diff[SGN_W-1]))) >>> 1;
        radial = $signed(SGN_W'(RADIAL_BINS / 2)) + hdiff;
        bin_bad = radial[SGN_W-1]
               || radial >= $signed(SGN_W'(RADIAL_BINS))
               || angle_full >= DIV_W'(ANGLE_BINS)
               || 32'(plane_reg) >= PLANES;
    end

    assign rdiff = (ra_reg > rb_reg) ? ra_reg - rb_reg : rb_reg - ra_reg;

    always_comb
    begin
        state_next     = state_reg;
        dsel_next      = dsel_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        ad_next        = ad_reg;
        sum_next       = sum_reg;
        plane_next     = plane_reg;
        radial_next    = radial_reg;
        angle_next     = angle_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        mem_we         = 1'b0;
        mem_wdata      = mem_rdata + 1'b1;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (evt_valid && !clr_busy)
                begin
                    dsel_next  = '0;
                    state_next = (evt.op == OP_READ) ? S_RCHK : S_DSTART;
                end
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    if (dsel_reg == DSEL_MOD)
                    begin
                        state_next = S_RAD;
                    end
                    else if (dsel_reg == DSEL_LAST_ID)
                    begin
                        state_next = S_RING;
                    end
                    else
                    begin
                        dsel_next  = dsel_reg + 1'b1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_RING:
            begin
                ra_next = RING_W'(q_reg[0]) + RING_W'(q_reg[1] * ac_reg)
                        + RING_W'(q_reg[2] * asac_reg);
                rb_next = RING_W'(q_reg[3]) + RING_W'(q_reg[4] * ac_reg)
                        + RING_W'(q_reg[5] * asac_reg);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                c1_next = XTAL_W'(evt_reg.rsector_a * tmtstc_reg)
                        + XTAL_W'(r_reg[2][4:0] * tstc_reg)
                        + XTAL_W'(r_reg[1][4:0] * tc_nz) + XTAL_W'(r_reg[0][4:0]);
                c2_next = XTAL_W'(evt_reg.rsector_b * tmtstc_reg)
                        + XTAL_W'(r_reg[5][4:0] * tstc_reg)
                        + XTAL_W'(r_reg[4][4:0] * tc_nz) + XTAL_W'(r_reg[3][4:0]);
                plane_next = 8'(ra_reg[3:0] * ring_count_reg) + 8'(rb_reg[3:0]);
                priority if (ra_reg >= RING_W'(ring_count_reg)
                          || rb_reg >= RING_W'(ring_count_reg))
                begin
                    pend_next  = '0;
                    pend_next.status = ST_RING_OOR;
                    state_next = S_OUT;
                end
                else if (rdiff > RING_W'(mrd_reg))
                begin
                    pend_next  = '0;
                    pend_next.status = ST_RING_DIFF;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                sum_next   = SUM_W'(c1_reg) + SUM_W'(c2_reg);
                ad_next    = (c1_reg > c2_reg) ? c1_reg - c2_reg : c2_reg - c1_reg;
                dsel_next  = DSEL_MOD;
                state_next = S_DSTART;
            end
            S_RAD:
            begin
                radial_next = radial[BIN_W-1:0];
                angle_next  = angle_full[BIN_W-1:0];
                if (bin_bad)
                begin
                    pend_next  = '0;
                    pend_next.status = ST_BIN_OOR;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_RCHK:
            begin
                radial_next = BIN_W'(evt_reg.read_radial);
                angle_next  = BIN_W'(evt_reg.read_angle);
                plane_next  = 8'(evt_reg.read_plane);
                if (32'(evt_reg.read_radial) >= RADIAL_BINS
                    || 32'(evt_reg.read_angle) >= ANGLE_BINS
                    || 32'(evt_reg.read_plane) >= PLANES)
                begin
                    pend_next.status     = ST_BIN_OOR;
                    pend_next.radial_bin = evt_reg.read_radial;
                    pend_next.angle_bin  = evt_reg.read_angle;
                    pend_next.plane      = evt_reg.read_plane;
                    pend_next.count      = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                addr_next = AW'((AW'(radial_reg) * AW'(ANGLE_BINS) + AW'(angle_reg))
                              * AW'(PLANES) + AW'(plane_reg));
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                pend_next.radial_bin = radial_reg[5:0];
                pend_next.angle_bin  = angle_reg[6:0];
                pend_next.plane      = plane_reg[5:0];
                priority if (evt_reg.op == OP_READ)
                begin
                    pend_next.status = ST_OK;
                    pend_next.count  = mem_rdata;
                end
                else if (mem_rdata == COUNT_MAX)
                begin
                    pend_next.status = ST_SAT;
                    pend_next.count  = COUNT_MAX;
                end
                else
                begin
                    mem_we = 1'b1;
                    pend_next.status = ST_OK;
                    pend_next.count  = mem_wdata;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_valid_reg)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dsel_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dsel_reg      <= dsel_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && evt_valid && !clr_busy)
        begin
            evt_reg <= evt;
        end
        if (state_reg == S_DWAIT && div_done && dsel_reg != DSEL_MOD)
        begin
            q_reg[dsel_reg] <= div_quo[7:0];
            r_reg[dsel_reg] <= div_rem[7:0];
        end
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        c1_reg     <= c1_next;
        c2_reg     <= c2_next;
        ad_reg     <= ad_next;
        sum_reg    <= sum_next;
        plane_reg  <= plane_next;
        radial_reg <= radial_next;
        angle_reg  <= angle_next;
        addr_reg   <= addr_next;
        pend_reg   <= pend_next;
        res_reg    <= res_next;
    end

    assign evt_stall = (state_reg != S_IDLE) || clr_busy;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the coincidence sinogram binner: directed table, then random events
`default_nettype none

module testbench;
    import pcsb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned CYCLE_LIMIT = 4_000_000;
    localparam int PHASES = 6;
    localparam int RANDOM_PER_PHASE = 257;
    localparam int DIR_ROWS = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  evt_valid;
    logic                  evt_stall;
    evt_t                  evt;
    logic                  res_valid;
    logic                  res_stall;
    res_t                  res;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pet_coincidence_sinogram_binner DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // geometry registers as the block holds them, indexed by register number
    longint unsigned geometry [8];
    logic [15:0]     bin_counts [int unsigned];
    res_t            pending_bins [$];
    res_t            hit_bins [$];
    int              error_count;
    longint unsigned cycle_count;
    int              burst_left;
    bit              valid_held;
    int              stall_mode;

    evt_t dir_evt [DIR_ROWS];
    bit   dir_typed [DIR_ROWS];
    res_t dir_result [DIR_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned nonzero(longint unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic longint unsigned ring_index(longint unsigned m, longint unsigned s,
                                                   longint unsigned c);
        return c / nonzero(geometry[CFG_TAN_CRYSTALS])
             + (s / nonzero(geometry[CFG_TAN_SUBMODULES])) * geometry[CFG_AXIAL_CRYSTALS]
             + (m / nonzero(geometry[CFG_TAN_MODULES])) * geometry[CFG_AXIAL_SUBMODULES]
               * geometry[CFG_AXIAL_CRYSTALS];
    endfunction

    function automatic longint unsigned crystal_index(longint unsigned rs, longint unsigned m,
                                                      longint unsigned s, longint unsigned c);
        longint unsigned tc, ts, tm;
        tc = nonzero(geometry[CFG_TAN_CRYSTALS]);
        ts = nonzero(geometry[CFG_TAN_SUBMODULES]);
        tm = nonzero(geometry[CFG_TAN_MODULES]);
        return rs * tm * ts * tc + (m % tm) * ts * tc + (s % ts) * tc + c % tc;
    endfunction

    // bins the event or reads a bin, updating the histogram copy
    function automatic res_t bin_event(evt_t e);
        res_t            r;
        longint unsigned ra, rb, rdiff, c1, c2, tot, half, sum, angle, ad, pl;
        longint          diff, radial;
        int unsigned     idx;
        r = '0;
        if (e.op == OP_READ)
        begin
            r.status     = ST_OK;
            r.radial_bin = e.read_radial;
            r.angle_bin  = e.read_angle;
            r.plane      = e.read_plane;
            idx = (e.read_radial * 128 + e.read_angle) * 64 + e.read_plane;
            r.count = bin_counts.exists(idx) ? bin_counts[idx] : 16'd0;
            return r;
        end
        ra = ring_index(e.module_a, e.submodule_a, e.crystal_a);
        rb = ring_index(e.module_b, e.submodule_b, e.crystal_b);
        if (ra >= geometry[CFG_RING_COUNT] || rb >= geometry[CFG_RING_COUNT])
        begin
            r.status = ST_RING_OOR;
            return r;
        end
        rdiff = (ra > rb) ? ra - rb : rb - ra;
        if (rdiff > geometry[CFG_MAX_RING_DIFF])
        begin
            r.status = ST_RING_DIFF;
            return r;
        end
        c1 = crystal_index(e.rsector_a, e.module_a, e.submodule_a, e.crystal_a);
        c2 = crystal_index(e.rsector_b, e.module_b, e.submodule_b, e.crystal_b);
        tot = nonzero(geometry[CFG_RSECTOR_COUNT]) * nonzero(geometry[CFG_TAN_MODULES])
            * nonzero(geometry[CFG_TAN_SUBMODULES]) * nonzero(geometry[CFG_TAN_CRYSTALS]);
        half = tot / 2;
        sum = c1 + c2;
        angle = ((sum + half) % tot) / 2;
        ad = (c1 > c2) ? c1 - c2 : c2 - c1;
        if (sum < (3 * tot) / 2 && sum >= half)
            diff = longint'(ad) - longint'(half);
        else
            diff = longint'(half) - longint'(ad);
        radial = 32 + diff / 2;
        pl = ra * geometry[CFG_RING_COUNT] + rb;
        if (radial < 0 || radial >= 64 || angle >= 128 || pl >= 64)
        begin
            r.status = ST_BIN_OOR;
            return r;
        end
        r.radial_bin = radial[5:0];
        r.angle_bin  = angle[6:0];
        r.plane      = pl[5:0];
        idx = 32'((radial * 128 + angle) * 64 + pl);
        if (!bin_counts.exists(idx))
            bin_counts[idx] = 16'd0;
        if (bin_counts[idx] == COUNT_MAX)
        begin
            r.status = ST_SAT;
            r.count  = COUNT_MAX;
            return r;
        end
        bin_counts[idx] = bin_counts[idx] + 16'd1;
        r.status = ST_OK;
        r.count  = bin_counts[idx];
        return r;
    endfunction

    function automatic evt_t add_event(int rsa, int ma, int sa, int ca,
                                       int rsb, int mb, int sb, int cb);
        evt_t e;
        e = '0;
        e.op = OP_ADD;
        e.rsector_a = 6'(rsa); e.module_a = 8'(ma); e.submodule_a = 8'(sa);
        e.crystal_a = 8'(ca);
        e.rsector_b = 6'(rsb); e.module_b = 8'(mb); e.submodule_b = 8'(sb);
        e.crystal_b = 8'(cb);
        return e;
    endfunction

    function automatic evt_t read_event(int r, int a, int p);
        evt_t e;
        e = '0;
        e.op = OP_READ;
        e.read_radial = 6'(r); e.read_angle = 7'(a); e.read_plane = 6'(p);
        return e;
    endfunction

    function automatic evt_t random_event();
        evt_t        e;
        int unsigned pick, tc, ts, tm, rs;
        res_t        h;
        pick = $urandom_range(0, 9);
        tc = 32'(nonzero(geometry[CFG_TAN_CRYSTALS]));
        ts = 32'(nonzero(geometry[CFG_TAN_SUBMODULES]));
        tm = 32'(nonzero(geometry[CFG_TAN_MODULES]));
        rs = 32'(nonzero(geometry[CFG_RSECTOR_COUNT]));
        if (pick < 2)
        begin
            e = evt_t'({$urandom, $urandom, 16'($urandom)});
        end
        else if (pick < 4)
        begin
            if (hit_bins.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                h = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
                e = read_event(h.radial_bin, h.angle_bin, h.plane);
            end
            else
                e = read_event($urandom_range(0, 63), $urandom_range(0, 127),
                               $urandom_range(0, 63));
        end
        else
        begin
            e = add_event($urandom_range(0, rs - 1) % 64, $urandom_range(0, 2 * tm - 1) % 256,
                          $urandom_range(0, 2 * ts - 1) % 256,
                          $urandom_range(0, 4 * tc - 1) % 256,
                          $urandom_range(0, rs - 1) % 64, $urandom_range(0, 2 * tm - 1) % 256,
                          $urandom_range(0, 2 * ts - 1) % 256,
                          $urandom_range(0, 4 * tc - 1) % 256);
        end
        return e;
    endfunction

    task automatic drive_event(evt_t e, bit typed, res_t typed_result);
        res_t predicted;
        evt <= e;
        evt_valid <= 1'b1;
        valid_held = 1'b1;
        @(posedge clk);
        while (evt_stall)
            @(posedge clk);
        predicted = bin_event(e);
        if (typed)
            predicted = typed_result;
        pending_bins.push_back(predicted);
        if (e.op == OP_ADD && predicted.status == ST_OK)
            hit_bins.push_back(predicted);
        if (burst_left == 0)
        begin
            evt_valid <= 1'b0;
            valid_held = 1'b0;
            repeat ($urandom_range(1, 25))
                @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
        else
            burst_left--;
    endtask

    task automatic drain_results();
        if (valid_held)
        begin
            evt_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_bins.size() != 0)
            @(posedge clk);
        repeat (120)
            @(posedge clk);
    endtask

    task automatic write_geometry(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == CFG_RSECTOR_COUNT)
            geometry[idx] = data & 7'h7f;
        else if (idx == CFG_RING_COUNT)
            geometry[idx] = data & 7'h0f;
        else if (idx == CFG_MAX_RING_DIFF)
            geometry[idx] = data & 7'h07;
        else
            geometry[idx] = data & 7'h1f;
    endtask

    task automatic load_geometry(int tc, int ts, int tm, int ac, int as_, int rs, int rc, int md);
        write_geometry(CFG_TAN_CRYSTALS, CFG_DATA_W'(tc));
        write_geometry(CFG_TAN_SUBMODULES, CFG_DATA_W'(ts));
        write_geometry(CFG_TAN_MODULES, CFG_DATA_W'(tm));
        write_geometry(CFG_AXIAL_CRYSTALS, CFG_DATA_W'(ac));
        write_geometry(CFG_AXIAL_SUBMODULES, CFG_DATA_W'(as_));
        write_geometry(CFG_RSECTOR_COUNT, CFG_DATA_W'(rs));
        write_geometry(CFG_RING_COUNT, CFG_DATA_W'(rc));
        write_geometry(CFG_MAX_RING_DIFF, CFG_DATA_W'(md));
        cfg_we <= 1'b0;
    endtask

    // result checker and stall pattern
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_bins.size() == 0)
            begin
                $error("unexpected transaction on result channel");
                error_count++;
            end
            else
            begin
                want = pending_bins.pop_front();
                if (res.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, res.status);
                    error_count++;
                end
                if (res.radial_bin !== want.radial_bin)
                begin
                    $error("radial_bin expected %0d actual %0d", want.radial_bin,
                           res.radial_bin);
                    error_count++;
                end
                if (res.angle_bin !== want.angle_bin)
                begin
                    $error("angle_bin expected %0d actual %0d", want.angle_bin,
                           res.angle_bin);
                    error_count++;
                end
                if (res.plane !== want.plane)
                begin
                    $error("plane expected %0d actual %0d", want.plane, res.plane);
                    error_count++;
                end
                if (res.count !== want.count)
                begin
                    $error("count expected %0d actual %0d", want.count, res.count);
                    error_count++;
                end
            end
        end
        if (cycle_count % 300 == 0)
            stall_mode = $urandom_range(0, 2);
        if (stall_mode == 0)
            res_stall <= 1'b0;
        else if (stall_mode == 1)
            res_stall <= ($urandom_range(0, 3) == 0);
        else
            res_stall <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        evt_valid = 1'b0;
        evt = '0;
        res_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        valid_held = 1'b0;
        stall_mode = 0;
        geometry = '{8, 1, 1, 8, 1, 32, 8, 7};

        dir_evt[0] = read_event(0, 0, 0);
        dir_typed[0] = 1'b1; dir_result[0] = res_t'{ST_OK, 6'd0, 7'd0, 6'd0, 16'd0};
        dir_evt[1] = read_event(63, 127, 63);
        dir_typed[1] = 1'b1; dir_result[1] = res_t'{ST_OK, 6'd63, 7'd127, 6'd63, 16'd0};
        dir_evt[2] = add_event(0, 0, 0, 255, 0, 0, 0, 0);
        dir_typed[2] = 1'b1; dir_result[2] = res_t'{ST_RING_OOR, 6'd0, 7'd0, 6'd0, 16'd0};
        dir_evt[3] = add_event(0, 0, 0, 0, 0, 0, 0, 0);
        dir_typed[3] = 1'b1; dir_result[3] = res_t'{ST_BIN_OOR, 6'd0, 7'd0, 6'd0, 16'd0};
        dir_evt[4] = add_event(63, 255, 255, 255, 63, 255, 255, 255);
        dir_typed[4] = 1'b1; dir_result[4] = res_t'{ST_RING_OOR, 6'd0, 7'd0, 6'd0, 16'd0};
        dir_evt[5] = add_event(0, 0, 0, 0, 16, 0, 0, 0);
        dir_evt[6] = add_event(0, 0, 0, 0, 16, 0, 0, 0);
        dir_evt[7] = add_event(40, 0, 0, 3, 60, 0, 0, 9);
        dir_evt[8] = add_event(5, 0, 0, 0, 21, 0, 0, 63);
        dir_evt[9] = read_event(32, 0, 0);
        for (int i = 5; i < DIR_ROWS; i++)
            dir_typed[i] = 1'b0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            drive_event(dir_evt[i], dir_typed[i], dir_result[i]);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: ;
                1: load_geometry(1, 1, 1, 1, 1, 1, 1, 0);
                2: load_geometry(4, 2, 2, 2, 2, 8, 8, 3);
                3: load_geometry(0, 0, 0, 0, 0, 0, 15, 7);
                4: load_geometry(16, 16, 16, 16, 16, 64, 8, 7);
                default: load_geometry(127, 127, 127, 127, 127, 127, 127, 127);
            endcase
            if (ph == 5)
                load_geometry(2, 1, 1, 2, 1, 16, 8, 2);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                drive_event(random_event(), 1'b0, '0);
            drain_results();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
